// ===== rtl/core/ata_pio_pkg.sv =====
package ata_pio_pkg;

   localparam int WORDS_PER_SECTOR = 256;
   localparam int MAX_SECTORS = 255;
   localparam int DELAY_READS = 4;
   localparam int MAX_RESULTS = 16;

   localparam logic [7:0] ST_BSY = 8'h80;
   localparam logic [7:0] ST_DF = 8'h20;
   localparam logic [7:0] ST_DRQ = 8'h08;
   localparam logic [7:0] ST_ERR = 8'h01;
   localparam logic [7:0] CMD_RD = 8'h20;
   localparam logic [7:0] CMD_WR = 8'h30;
   localparam logic [7:0] CMD_FLUSH = 8'he7;
   localparam logic [7:0] DEV_BASE = 8'he0;
   localparam logic [47:0] LBA28_MAX = 48'h000_0fff_ffff;

   typedef enum logic [1:0] {
      OP_START_RD = 2'd0,
      OP_START_WR = 2'd1,
      OP_RESP     = 2'd2,
      OP_HOST_WR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      K_RD8  = 3'd0,
      K_WR8  = 3'd1,
      K_RD16 = 3'd2,
      K_WR16 = 3'd3,
      K_HOST = 3'd4,
      K_DONE = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_SEL_DELAY   = 4'd1,
      PH_POLL_DELAY  = 4'd2,
      PH_POLL_STATUS = 4'd3,
      PH_READ_DATA   = 4'd4,
      PH_GAP_DELAY   = 4'd5,
      PH_WRITE_DATA  = 4'd6
   } phase_type;

   typedef enum logic [2:0] {
      CSR_IO_BASE    = 3'd0,
      CSR_DELAY_PORT = 3'd1,
      CSR_SLAVE      = 3'd2,
      CSR_PRESENT    = 3'd3,
      CSR_LIMIT      = 3'd4
   } csr_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] port;
      logic [15:0] value;
      logic        ok;
   } res_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [47:0] lba;
      logic [15:0] num_sectors;
      logic [15:0] bus_data;
      logic [15:0] host_word;
   } item_type;

   typedef struct packed {
      logic [15:0] io_base;
      logic [15:0] delay_port;
      logic        drive_slave;
      logic        device_present;
      logic [31:0] sector_limit;
   } cfg_type;

   // a batch of results for one transaction
   typedef struct packed {
      logic [4:0]               count;
      res_type [MAX_RESULTS-1:0] res;
   } batch_type;

endpackage

// ===== rtl/core/ata_pio_if.sv =====
interface ata_pio_req_if;
   logic                    valid;
   logic                    ready;
   ata_pio_pkg::item_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ata_pio_rsp_if;
   logic                    valid;
   logic                    ready;
   ata_pio_pkg::res_type    data;
   logic                    last;
   modport source (output valid, output data, output last, input ready);
   modport sink (input valid, input data, input last, output ready);
endinterface

// ===== rtl/core/ata_pio_csr.sv =====
module ata_pio_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output ata_pio_pkg::cfg_type  cfg
);
   ata_pio_pkg::cfg_type cfg_ff;

   // decode register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.io_base <= 16'h01f0;
         cfg_ff.delay_port <= 16'h03f6;
         cfg_ff.drive_slave <= 1'b0;
         cfg_ff.device_present <= 1'b0;
         cfg_ff.sector_limit <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            ata_pio_pkg::CSR_IO_BASE:    cfg_ff.io_base <= csr_wdata[15:0];
            ata_pio_pkg::CSR_DELAY_PORT: cfg_ff.delay_port <= csr_wdata[15:0];
            ata_pio_pkg::CSR_SLAVE:      cfg_ff.drive_slave <= csr_wdata[0];
            ata_pio_pkg::CSR_PRESENT:    cfg_ff.device_present <= csr_wdata[0];
            ata_pio_pkg::CSR_LIMIT:      cfg_ff.sector_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== rtl/core/ata_pio_core.sv =====
module ata_pio_core (
   input  logic                    clock,
   input  logic                    reset,
   input  ata_pio_pkg::cfg_type    cfg,
   input  logic                    in_valid,
   input  ata_pio_pkg::item_type   in_item,
   output logic                    in_ready,
   output logic                    bat_valid,
   output ata_pio_pkg::batch_type  bat,
   input  logic                    bat_take
);
   localparam int WIW = $clog2(ata_pio_pkg::WORDS_PER_SECTOR) + 1;

   ata_pio_pkg::phase_type phase_ff, phase_in;
   logic is_write_ff, is_write_in;
   logic [7:0] sectors_left_ff, sectors_left_in;
   logic [WIW-1:0] word_index_ff, word_index_in;
   logic [2:0] discard_ff, discard_in;
   logic drq_ff, drq_in, flush_ff, flush_in;
   logic [7:0] count_ff, count_in;
   logic [27:0] lba_ff, lba_in;
   logic bat_valid_ff;
   ata_pio_pkg::batch_type bat_ff, bat_in;

   logic take;
   assign in_ready = !bat_valid_ff || bat_take;
   assign take = in_valid && in_ready;

   function automatic logic [15:0] iop(input logic [15:0] b, input logic [2:0] r);
      iop = b + {13'd0, r};
   endfunction

   // compute next state and the result batch for one transaction
   always_comb begin
      logic [4:0] n;
      logic [7:0] st;
      logic [48:0] sum;
      phase_in = phase_ff;
      is_write_in = is_write_ff;
      sectors_left_in = sectors_left_ff;
      word_index_in = word_index_ff;
      discard_in = discard_ff;
      drq_in = drq_ff;
      flush_in = flush_ff;
      count_in = count_ff;
      lba_in = lba_ff;
      bat_in = '0;
      n = '0;
      st = in_item.bus_data[7:0];
      sum = {1'b0, in_item.lba} + {33'd0, in_item.num_sectors};
      unique case (in_item.opcode)
         ata_pio_pkg::OP_START_RD, ata_pio_pkg::OP_START_WR: begin
            if (phase_ff == ata_pio_pkg::PH_IDLE) begin
               if (!cfg.device_present || in_item.num_sectors == 16'd0
                   || in_item.num_sectors > 16'(ata_pio_pkg::MAX_SECTORS)
                   || sum > {17'd0, cfg.sector_limit}
                   || in_item.lba > ata_pio_pkg::LBA28_MAX) begin
                  bat_in.res[0] = '{ata_pio_pkg::K_DONE, 16'd0, 16'd0, 1'b0};
                  n = 5'd1;
                  sectors_left_in = '0; word_index_in = '0; discard_in = '0;
                  drq_in = 1'b0; flush_in = 1'b0;
               end else begin
                  is_write_in = in_item.opcode[0];
                  lba_in = in_item.lba[27:0];
                  count_in = in_item.num_sectors[7:0];
                  sectors_left_in = in_item.num_sectors[7:0];
                  word_index_in = '0; flush_in = 1'b0; drq_in = 1'b0;
                  bat_in.res[0] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd6),
                     {8'd0, ata_pio_pkg::DEV_BASE | {3'd0, cfg.drive_slave, 4'd0}}, 1'b0};
                  bat_in.res[1] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                  n = 5'd2;
                  phase_in = ata_pio_pkg::PH_SEL_DELAY;
                  discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
               end
            end
         end
         ata_pio_pkg::OP_RESP: begin
            unique case (phase_ff)
               ata_pio_pkg::PH_SEL_DELAY, ata_pio_pkg::PH_POLL_DELAY,
               ata_pio_pkg::PH_GAP_DELAY: begin
                  if (discard_ff != 3'd0) begin
                     discard_in = discard_ff - 3'd1;
                     bat_in.res[0] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                     n = 5'd1;
                  end else if (phase_ff == ata_pio_pkg::PH_SEL_DELAY) begin
                     bat_in.res[0] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd2),
                        {8'd0, count_ff}, 1'b0};
                     bat_in.res[1] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd3),
                        {8'd0, lba_ff[7:0]}, 1'b0};
                     bat_in.res[2] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd4),
                        {8'd0, lba_ff[15:8]}, 1'b0};
                     bat_in.res[3] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd5),
                        {8'd0, lba_ff[23:16]}, 1'b0};
                     bat_in.res[4] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd6),
                        {8'd0, ata_pio_pkg::DEV_BASE | {3'd0, cfg.drive_slave, lba_ff[27:24]}},
                        1'b0};
                     bat_in.res[5] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd7),
                        {8'd0, is_write_ff ? ata_pio_pkg::CMD_WR : ata_pio_pkg::CMD_RD}, 1'b0};
                     bat_in.res[6] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                     n = 5'd7;
                     drq_in = 1'b1;
                     phase_in = ata_pio_pkg::PH_POLL_DELAY;
                     discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
                  end else if (phase_ff == ata_pio_pkg::PH_GAP_DELAY) begin
                     drq_in = sectors_left_ff != 8'd0;
                     bat_in.res[0] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                     n = 5'd1;
                     phase_in = ata_pio_pkg::PH_POLL_DELAY;
                     discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
                  end else begin
                     phase_in = ata_pio_pkg::PH_POLL_STATUS;
                     bat_in.res[0] = '{ata_pio_pkg::K_RD8, iop(cfg.io_base, 3'd7), 16'd0, 1'b0};
                     n = 5'd1;
                  end
               end
               ata_pio_pkg::PH_POLL_STATUS: begin
                  logic fin, fok;
                  fin = 1'b0; fok = 1'b0;
                  if ((st & ata_pio_pkg::ST_BSY) != 8'd0) begin
                     bat_in.res[0] = '{ata_pio_pkg::K_RD8, iop(cfg.io_base, 3'd7), 16'd0, 1'b0};
                     n = 5'd1;
                  end else if ((st & (ata_pio_pkg::ST_ERR | ata_pio_pkg::ST_DF)) != 8'd0) begin
                     fin = 1'b1;
                  end else if (drq_ff) begin
                     if ((st & ata_pio_pkg::ST_DRQ) == 8'd0) fin = 1'b1;
                     else begin
                        word_index_in = '0;
                        if (is_write_ff) phase_in = ata_pio_pkg::PH_WRITE_DATA;
                        else begin
                           phase_in = ata_pio_pkg::PH_READ_DATA;
                           bat_in.res[0] = '{ata_pio_pkg::K_RD16, iop(cfg.io_base, 3'd0),
                              16'd0, 1'b0};
                           n = 5'd1;
                        end
                     end
                  end else if (!is_write_ff || flush_ff) begin
                     fin = 1'b1; fok = 1'b1;
                  end else if (sectors_left_ff != 8'd0) begin
                     drq_in = 1'b1;
                     phase_in = ata_pio_pkg::PH_POLL_DELAY;
                     discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
                     bat_in.res[0] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                     n = 5'd1;
                  end else begin
                     flush_in = 1'b1; drq_in = 1'b0;
                     bat_in.res[0] = '{ata_pio_pkg::K_WR8, iop(cfg.io_base, 3'd7),
                        {8'd0, ata_pio_pkg::CMD_FLUSH}, 1'b0};
                     bat_in.res[1] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                     n = 5'd2;
                     phase_in = ata_pio_pkg::PH_POLL_DELAY;
                     discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
                  end
                  if (fin) begin
                     phase_in = ata_pio_pkg::PH_IDLE;
                     sectors_left_in = '0; word_index_in = '0; discard_in = '0;
                     drq_in = 1'b0; flush_in = 1'b0;
                     bat_in.res[0] = '{ata_pio_pkg::K_DONE, 16'd0, 16'd0, fok};
                     n = 5'd1;
                  end
               end
               ata_pio_pkg::PH_READ_DATA: begin
                  bat_in.res[0] = '{ata_pio_pkg::K_HOST, 16'd0, in_item.bus_data, 1'b0};
                  if (word_index_ff + 1'b1 < WIW'(ata_pio_pkg::WORDS_PER_SECTOR)) begin
                     word_index_in = word_index_ff + 1'b1;
                     bat_in.res[1] = '{ata_pio_pkg::K_RD16, iop(cfg.io_base, 3'd0), 16'd0, 1'b0};
                  end else begin
                     word_index_in = '0;
                     sectors_left_in = sectors_left_ff - 8'd1;
                     phase_in = ata_pio_pkg::PH_GAP_DELAY;
                     discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
                     bat_in.res[1] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                  end
                  n = 5'd2;
               end
               default: ;
            endcase
         end
         default: begin
            if (phase_ff == ata_pio_pkg::PH_WRITE_DATA) begin
               bat_in.res[0] = '{ata_pio_pkg::K_WR16, iop(cfg.io_base, 3'd0),
                  in_item.host_word, 1'b0};
               n = 5'd1;
               if (word_index_ff + 1'b1 >= WIW'(ata_pio_pkg::WORDS_PER_SECTOR)) begin
                  word_index_in = '0;
                  sectors_left_in = sectors_left_ff - 8'd1;
                  drq_in = 1'b0;
                  phase_in = ata_pio_pkg::PH_POLL_DELAY;
                  discard_in = 3'(ata_pio_pkg::DELAY_READS - 1);
                  bat_in.res[1] = '{ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0};
                  n = 5'd2;
               end else begin
                  word_index_in = word_index_ff + 1'b1;
               end
            end
         end
      endcase
      bat_in.count = n;
   end

   // advance state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ata_pio_pkg::PH_IDLE;
         is_write_ff <= 1'b0;
         sectors_left_ff <= '0;
         word_index_ff <= '0;
         discard_ff <= '0;
         drq_ff <= 1'b0;
         flush_ff <= 1'b0;
         count_ff <= '0;
         lba_ff <= '0;
         bat_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            is_write_ff <= is_write_in;
            sectors_left_ff <= sectors_left_in;
            word_index_ff <= word_index_in;
            discard_ff <= discard_in;
            drq_ff <= drq_in;
            flush_ff <= flush_in;
            count_ff <= count_in;
            lba_ff <= lba_in;
            bat_valid_ff <= bat_in.count != 5'd0;
         end else if (bat_take) begin
            bat_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) bat_ff <= bat_in;
   end

   assign bat_valid = bat_valid_ff;
   assign bat = bat_ff;

   a_words: assert property (@(posedge clock) disable iff (reset)
      word_index_ff < WIW'(ata_pio_pkg::WORDS_PER_SECTOR)) else $error("word index overrun");
   a_batch: assert property (@(posedge clock) disable iff (reset)
      bat_valid_ff |-> bat_ff.count != 5'd0 && bat_ff.count <= 5'd16)
      else $error("bad batch size");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      bat_valid_ff && !bat_take |=> bat_valid_ff && $stable(bat_ff))
      else $error("batch lost");
endmodule

// ===== rtl/core/ata_pio_out.sv =====
module ata_pio_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   bat_valid,
   input  ata_pio_pkg::batch_type bat,
   output logic                   bat_take,
   ata_pio_rsp_if.source          rsp
);
   logic [4:0] idx_ff, idx_in;
   logic last;

   assign last = (idx_ff + 5'd1) == bat.count;
   assign bat_take = bat_valid && rsp.ready && last;
   assign idx_in = bat_take ? 5'd0 : idx_ff + 5'd1;

   // step through the batch one result per cycle while the receiver is ready
   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (bat_valid && rsp.ready) idx_ff <= idx_in;
   end

   assign rsp.valid = bat_valid;
   assign rsp.data = bat.res[idx_ff[3:0]];
   assign rsp.last = last;

   a_idx: assert property (@(posedge clock) disable iff (reset)
      bat_valid |-> idx_ff < bat.count) else $error("index past batch");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      !bat_valid |-> idx_ff == 5'd0) else $error("index not cleared");
   a_ret: assert property (@(posedge clock) disable iff (reset)
      bat_take |=> idx_ff == 5'd0) else $error("index not reset");
endmodule

// ===== rtl/core/ata_pio_sector_sequencer_top.sv =====
// Results are registered and offered from the cycle after acceptance.
// Throughput: one transaction per cycle when it causes at most one result
// and the receiver is ready; results leave one per cycle through the output
// stage while ready, and the next transaction waits until the last has left.
// Reset: synchronous active high; returns to idle and restores default CSRs.
module ata_pio_sector_sequencer_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   ata_pio_req_if.sink   req,
   ata_pio_rsp_if.source rsp
);
   ata_pio_pkg::cfg_type cfg;
   ata_pio_pkg::batch_type bat;
   logic bat_valid, bat_take;

   ata_pio_csr u_csr (.clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg);

   ata_pio_core u_core (.clock, .reset, .cfg, .in_valid(req.valid), .in_item(req.data),
      .in_ready(req.ready), .bat_valid, .bat, .bat_take);

   ata_pio_out u_out (.clock, .reset, .bat_valid, .bat, .bat_take, .rsp);
endmodule

// ===== tb/ata_pio_sector_sequencer_top_test.sv =====
module ata_pio_sector_sequencer_top_test;

   typedef struct {
      ata_pio_pkg::res_type res;
      logic                 last;
   } bus_result_type;

   typedef struct {
      ata_pio_pkg::op_type   op;
      logic [47:0]           lba;
      logic [15:0]           cnt;
      logic [15:0]           bus;
      logic [15:0]           hw;
      bit                    chk;
      ata_pio_pkg::kind_type kind;
      logic                  ok;
   } stim_row_type;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   ata_pio_req_if req_ch();
   ata_pio_rsp_if rsp_ch();

   ata_pio_sector_sequencer_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req_ch), .rsp(rsp_ch)
   );

   // expected bus results, oldest first
   bus_result_type bus_result_q[$];
   int errors = 0;
   int tx_idle = 9;
   int rx_idle = 59;
   int rand_count = 0;
   bit hold_rsp = 0;

   // shadow of the sequencer
   ata_pio_pkg::cfg_type   cfg;
   ata_pio_pkg::phase_type ph;
   logic        wr;
   logic [7:0]  left;
   logic [8:0]  widx;
   logic [2:0]  disc;
   logic        drq_chk;
   logic        flush;
   logic [15:0] cur_cnt;
   logic [47:0] cur_lba;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   function automatic logic [15:0] io_port(input int r);
      return cfg.io_base + 16'(r);
   endfunction

   function automatic void push(input ata_pio_pkg::kind_type k, input logic [15:0] port,
                                input logic [15:0] value, input logic ok);
      bus_result_type e;
      e.res.kind = k;
      e.res.port = port;
      e.res.value = value;
      e.res.ok = ok;
      e.last = 0;
      bus_result_q.push_back(e);
   endfunction

   function automatic void start_delay(input ata_pio_pkg::phase_type nxt);
      ph = nxt;
      disc = 3'(ata_pio_pkg::DELAY_READS - 1);
      push(ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0);
   endfunction

   function automatic void finish_xfer(input logic ok);
      ph = ata_pio_pkg::PH_IDLE;
      left = 0;
      widx = 0;
      disc = 0;
      drq_chk = 0;
      flush = 0;
      push(ata_pio_pkg::K_DONE, 16'd0, 16'd0, ok);
   endfunction

   function automatic void after_status(input logic [7:0] st);
      if (st & ata_pio_pkg::ST_BSY) push(ata_pio_pkg::K_RD8, io_port(7), 16'd0, 1'b0);
      else if (st & (ata_pio_pkg::ST_ERR | ata_pio_pkg::ST_DF)) finish_xfer(1'b0);
      else if (drq_chk) begin
         if ((st & ata_pio_pkg::ST_DRQ) == 0) finish_xfer(1'b0);
         else begin
            widx = 0;
            if (wr) ph = ata_pio_pkg::PH_WRITE_DATA;
            else begin
               ph = ata_pio_pkg::PH_READ_DATA;
               push(ata_pio_pkg::K_RD16, io_port(0), 16'd0, 1'b0);
            end
         end
      end else if (!wr || flush) finish_xfer(1'b1);
      else if (left > 0) begin
         drq_chk = 1;
         start_delay(ata_pio_pkg::PH_POLL_DELAY);
      end else begin
         flush = 1;
         drq_chk = 0;
         push(ata_pio_pkg::K_WR8, io_port(7), {8'd0, ata_pio_pkg::CMD_FLUSH}, 1'b0);
         start_delay(ata_pio_pkg::PH_POLL_DELAY);
      end
   endfunction

   function automatic void on_resp(input logic [15:0] data);
      logic [7:0] dev;
      if (ph == ata_pio_pkg::PH_SEL_DELAY || ph == ata_pio_pkg::PH_POLL_DELAY ||
          ph == ata_pio_pkg::PH_GAP_DELAY) begin
         if (disc > 0) begin
            disc--;
            push(ata_pio_pkg::K_RD8, cfg.delay_port, 16'd0, 1'b0);
         end else if (ph == ata_pio_pkg::PH_SEL_DELAY) begin
            dev = ata_pio_pkg::DEV_BASE | {3'd0, cfg.drive_slave, cur_lba[27:24]};
            push(ata_pio_pkg::K_WR8, io_port(2), {8'd0, cur_cnt[7:0]}, 1'b0);
            push(ata_pio_pkg::K_WR8, io_port(3), {8'd0, cur_lba[7:0]}, 1'b0);
            push(ata_pio_pkg::K_WR8, io_port(4), {8'd0, cur_lba[15:8]}, 1'b0);
            push(ata_pio_pkg::K_WR8, io_port(5), {8'd0, cur_lba[23:16]}, 1'b0);
            push(ata_pio_pkg::K_WR8, io_port(6), {8'd0, dev}, 1'b0);
            push(ata_pio_pkg::K_WR8, io_port(7),
                 {8'd0, wr ? ata_pio_pkg::CMD_WR : ata_pio_pkg::CMD_RD}, 1'b0);
            drq_chk = 1;
            start_delay(ata_pio_pkg::PH_POLL_DELAY);
         end else if (ph == ata_pio_pkg::PH_GAP_DELAY) begin
            drq_chk = (left > 0);
            start_delay(ata_pio_pkg::PH_POLL_DELAY);
         end else begin
            ph = ata_pio_pkg::PH_POLL_STATUS;
            push(ata_pio_pkg::K_RD8, io_port(7), 16'd0, 1'b0);
         end
      end else if (ph == ata_pio_pkg::PH_POLL_STATUS) after_status(data[7:0]);
      else if (ph == ata_pio_pkg::PH_READ_DATA) begin
         push(ata_pio_pkg::K_HOST, 16'd0, data, 1'b0);
         widx++;
         if (widx < ata_pio_pkg::WORDS_PER_SECTOR)
            push(ata_pio_pkg::K_RD16, io_port(0), 16'd0, 1'b0);
         else begin
            widx = 0;
            left--;
            start_delay(ata_pio_pkg::PH_GAP_DELAY);
         end
      end
   endfunction

   // work out the results of one accepted transaction
   function automatic int predict_item(input ata_pio_pkg::item_type it,
                                       output bus_result_type first);
      int n0;
      logic [63:0] sum;
      n0 = bus_result_q.size();
      case (ata_pio_pkg::op_type'(it.opcode))
         ata_pio_pkg::OP_START_RD, ata_pio_pkg::OP_START_WR:
            if (ph == ata_pio_pkg::PH_IDLE) begin
               sum = {16'd0, it.lba} + 64'(it.num_sectors);
               if (!cfg.device_present || it.num_sectors == 0 ||
                   it.num_sectors > ata_pio_pkg::MAX_SECTORS ||
                   sum > {32'd0, cfg.sector_limit} || it.lba > ata_pio_pkg::LBA28_MAX) begin
                  finish_xfer(1'b0);
               end else begin
                  wr = it.opcode[0];
                  cur_lba = it.lba;
                  cur_cnt = it.num_sectors;
                  left = it.num_sectors[7:0];
                  widx = 0;
                  flush = 0;
                  drq_chk = 0;
                  push(ata_pio_pkg::K_WR8, io_port(6),
                       {8'd0, ata_pio_pkg::DEV_BASE | {3'd0, cfg.drive_slave, 4'd0}}, 1'b0);
                  start_delay(ata_pio_pkg::PH_SEL_DELAY);
               end
            end
         ata_pio_pkg::OP_RESP: on_resp(it.bus_data);
         default: if (ph == ata_pio_pkg::PH_WRITE_DATA) begin
            push(ata_pio_pkg::K_WR16, io_port(0), it.host_word, 1'b0);
            widx++;
            if (widx >= ata_pio_pkg::WORDS_PER_SECTOR) begin
               widx = 0;
               left--;
               drq_chk = 0;
               start_delay(ata_pio_pkg::PH_POLL_DELAY);
            end
         end
      endcase
      if (bus_result_q.size() > n0) begin
         bus_result_q[bus_result_q.size() - 1].last = 1;
         first = bus_result_q[n0];
      end
      return bus_result_q.size() - n0;
   endfunction

   // offer one transaction, wait for acceptance, then predict
   task automatic send(input ata_pio_pkg::item_type it, output int produced,
                       output bus_result_type first);
      while ($urandom_range(99) < tx_idle) begin
         @(negedge clock);
         req_ch.valid <= 0;
      end
      @(negedge clock);
      req_ch.valid <= 1;
      req_ch.data <= it;
      do @(posedge clock); while (!req_ch.ready);
      produced = predict_item(it, first);
   endtask

   // write every register once the sequencer has gone quiet
   task automatic write_config(input ata_pio_pkg::cfg_type c);
      @(negedge clock);
      req_ch.valid <= 0;
      while (bus_result_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_we <= 1;
         csr_index <= 3'(i);
         case (ata_pio_pkg::csr_type'(i))
            ata_pio_pkg::CSR_IO_BASE:    csr_wdata <= {16'd0, c.io_base};
            ata_pio_pkg::CSR_DELAY_PORT: csr_wdata <= {16'd0, c.delay_port};
            ata_pio_pkg::CSR_SLAVE:      csr_wdata <= {31'd0, c.drive_slave};
            ata_pio_pkg::CSR_PRESENT:    csr_wdata <= {31'd0, c.device_present};
            default:                     csr_wdata <= c.sector_limit;
         endcase
      end
      @(negedge clock);
      csr_we <= 0;
      cfg = c;
   endtask

   function automatic ata_pio_pkg::cfg_type make_cfg(input logic [15:0] io,
                                                     input logic [15:0] ctl,
                                                     input logic sl, input logic pr,
                                                     input logic [31:0] lim);
      ata_pio_pkg::cfg_type c;
      c.io_base = io;
      c.delay_port = ctl;
      c.drive_slave = sl;
      c.device_present = pr;
      c.sector_limit = lim;
      return c;
   endfunction

   // pick the next transaction from the shadow phase; mostly well formed
   function automatic ata_pio_pkg::item_type make_item();
      ata_pio_pkg::item_type it;
      logic [31:0] hi;
      logic [7:0] st;
      it.lba = 48'({$urandom, $urandom} >> $urandom_range(47));
      it.num_sectors = 16'($urandom) >> $urandom_range(15);
      it.bus_data = 16'($urandom);
      it.host_word = 16'($urandom);
      it.opcode = 2'($urandom);
      if ($urandom_range(99) < 4) return it;
      case (ph)
         ata_pio_pkg::PH_IDLE: begin
            it.opcode = $urandom_range(1) ? ata_pio_pkg::OP_START_WR : ata_pio_pkg::OP_START_RD;
            if ($urandom_range(99) < 75) begin
               it.num_sectors = ($urandom_range(9) == 0) ? 16'd2 : 16'd1;
               if (cfg.sector_limit >= it.num_sectors) begin
                  hi = cfg.sector_limit - it.num_sectors;
                  if (hi > ata_pio_pkg::LBA28_MAX) hi = 32'(ata_pio_pkg::LBA28_MAX);
                  it.lba = 48'($urandom_range(hi));
               end
            end
         end
         ata_pio_pkg::PH_WRITE_DATA: it.opcode = ata_pio_pkg::OP_HOST_WR;
         ata_pio_pkg::PH_POLL_STATUS: begin
            it.opcode = ata_pio_pkg::OP_RESP;
            st = 8'($urandom) & ~(ata_pio_pkg::ST_BSY | ata_pio_pkg::ST_ERR | ata_pio_pkg::ST_DF);
            if (drq_chk) st = st | ata_pio_pkg::ST_DRQ;
            case ($urandom_range(99)) inside
               [0:13]:  st = st | ata_pio_pkg::ST_BSY | 8'($urandom);
               [14:15]: st = st | ata_pio_pkg::ST_ERR;
               [16:17]: st = st | ata_pio_pkg::ST_DF;
               [18:20]: st = st & ~ata_pio_pkg::ST_DRQ;
               default: ;
            endcase
            it.bus_data = {8'($urandom), st};
         end
         default: it.opcode = ata_pio_pkg::OP_RESP;
      endcase
      return it;
   endfunction

   stim_row_type rows[22];

   initial begin
      ata_pio_pkg::item_type it;
      int produced;
      bus_result_type first;
      cfg = make_cfg(16'h01f0, 16'h03f6, 1'b0, 1'b0, 32'd0);
      ph = ata_pio_pkg::PH_IDLE; wr = 0; left = 0; widx = 0; disc = 0; drq_chk = 0;
      flush = 0; cur_cnt = 0; cur_lba = 0;
      rows = '{
         '{ata_pio_pkg::OP_START_RD, 48'd0, 16'd1, 16'd0, 16'd0, 1, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'hffff, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_HOST_WR, 48'd0, 16'd0, 16'd0, 16'hffff, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_RD, 48'd0, 16'd0, 16'd0, 16'd0, 1, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_WR, 48'd0, 16'd256, 16'd0, 16'd0, 1, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_RD, 48'd0, 16'hffff, 16'd0, 16'd0, 1, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_RD, 48'h000010000000, 16'd1, 16'd0, 16'd0, 1,
           ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_WR, 48'hffffffffffff, 16'd1, 16'd0, 16'd0, 1,
           ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_WR, 48'h00000fffffff, 16'd1, 16'd0, 16'd0, 1,
           ata_pio_pkg::K_WR8, 1'b0},
         '{ata_pio_pkg::OP_START_RD, 48'd0, 16'd1, 16'd0, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_HOST_WR, 48'd0, 16'd0, 16'd0, 16'h1234, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'hffff, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h0000, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h5a5a, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'ha5a5, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h0000, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h0000, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h0000, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h0000, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'h0080, 16'd0, 0, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_RESP, 48'd0, 16'd0, 16'hff21, 16'd0, 1, ata_pio_pkg::K_DONE, 1'b0},
         '{ata_pio_pkg::OP_START_RD, 48'd5, 16'd2, 16'd0, 16'd0, 1, ata_pio_pkg::K_WR8, 1'b0}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed table
      foreach (rows[i]) begin
         if (i == 3) write_config(make_cfg(16'hfff8, 16'hffff, 1'b1, 1'b1, 32'hffffffff));
         it.opcode = rows[i].op;
         it.lba = rows[i].lba;
         it.num_sectors = rows[i].cnt;
         it.bus_data = rows[i].bus;
         it.host_word = rows[i].hw;
         send(it, produced, first);
         if (rows[i].chk && (produced == 0 || first.res.kind != rows[i].kind ||
                             first.res.ok != rows[i].ok)) begin
            errors++;
            if (errors <= 10)
               $display("row %0d: expected kind %0d ok %0d, predicted %0d results kind %0d ok %0d",
                        i, rows[i].kind, rows[i].ok, produced, first.res.kind, first.res.ok);
         end
      end

      // random part, cycling through register settings and idling modes
      while (rand_count < 430) begin
         if (ph == ata_pio_pkg::PH_IDLE && $urandom_range(7) == 0)
            case ($urandom_range(3))
               0: write_config(make_cfg(16'h01f0, 16'h03f6, 1'b0, 1'b1, 32'd3));
               1: write_config(make_cfg(16'h0000, 16'hffff, 1'b1, 1'b1, 32'h10000000));
               2: write_config(make_cfg(16'h0170, 16'h0376, 1'b0, 1'b0, 32'hffffffff));
               default: write_config(make_cfg(16'hffff, 16'h0000, 1'b1, 1'b1, 32'hffffffff));
            endcase
         if (rand_count < 143) begin
            tx_idle = 9; rx_idle = 59;
         end else if (rand_count < 286) begin
            tx_idle = 59; rx_idle = 9;
         end else begin
            tx_idle = 0; rx_idle = 0;
         end
         send(make_item(), produced, first);
         if (produced > 0) rand_count++;
      end

      // drain
      @(negedge clock);
      req_ch.valid <= 0;
      while (bus_result_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // long receiver hold-off so the output backs up into the input
   initial begin
      wait (rand_count >= 200);
      hold_rsp = 1;
      repeat (400) @(negedge clock);
      hold_rsp = 0;
   end

   // drive result ready
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && !hold_rsp && ($urandom_range(99) >= rx_idle);
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      bus_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (bus_result_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result kind %0d port %h value %h ok %0d last %0d",
                        rsp_ch.data.kind, rsp_ch.data.port, rsp_ch.data.value,
                        rsp_ch.data.ok, rsp_ch.last);
         end else begin
            e = bus_result_q.pop_front();
            if (rsp_ch.data.kind !== e.res.kind || rsp_ch.data.port !== e.res.port ||
                rsp_ch.data.value !== e.res.value || rsp_ch.data.ok !== e.res.ok ||
                rsp_ch.last !== e.last) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: expected kind %0d port %h value %h ok %0d last %0d,",
                            " got kind %0d port %h value %h ok %0d last %0d"},
                           e.res.kind, e.res.port, e.res.value, e.res.ok, e.last,
                           rsp_ch.data.kind, rsp_ch.data.port, rsp_ch.data.value,
                           rsp_ch.data.ok, rsp_ch.last);
            end
         end
      end
   end

   // end the run when no transaction moves for too long
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
